/* rtl/core/ukt_pkg.sv */
package ukt_pkg;

    localparam int UKT_DEPTH = 32;

    localparam int MODE_W    = 2;
    localparam int KEY_W     = 31;
    localparam int PAY_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 5;
    localparam int COUNT_W   = 6;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_SWAP   = 2'd2,
        MODE_SHIFT  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_INVALID  = 3'd4
    } status_t;

endpackage

/* rtl/core/ukt_req_if.sv */
interface ukt_req_if
    import ukt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;

    modport source (output valid, output mode, output key, output payload, input ready);
    modport sink   (input valid, input mode, input key, input payload, output ready);
endinterface

/* rtl/core/ukt_rsp_if.sv */
interface ukt_rsp_if
    import ukt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [PAY_W-1:0]    found_payload;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output position, output found_payload,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input position, input found_payload,
                    input entry_count, output ready);
endinterface

/* rtl/core/ukt_ram.sv */
module ukt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/unordered_key_table.sv */
// Packed key table: up to DEPTH entries of a nonzero key and a payload word.
// req transfers carry mode, key and payload: insert appends at the first free
// slot, lookup returns slot and payload, swap removal moves the last entry into
// the vacated slot, shift removal moves every later entry down one slot.
// rsp transfers carry status, position, found payload and the entry count
// after the request; each request gives exactly one response.
// One request is in work at a time. The search reads one key a cycle through
// the single read port of the key memory and compares it the cycle after:
// A hit ends the search, and a miss ends it after the last entry. Swap removal
// then reads the last entry and writes it into the vacated slot (not when the
// hit was the last entry); shift removal moves each later entry down in turn.
// The response register is loaded last, and the next request is taken once
// the block is back in its idle state.
// A response then waits in the output register; the next request is taken
// while it waits, but its own response holds until the receiver takes the
// previous one, so a stalled receiver stalls the block after one request.
// Reset empties the table at once: no memory pass is needed, since only
// entries in slots below the entry count are ever used.
module unordered_key_table
    import ukt_pkg::*;
#(
    parameter int DEPTH = UKT_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    ukt_req_if.sink   req,
    ukt_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SWAP_RD,
        S_SWAP_WR,
        S_SHIFT,
        S_FIN
    } state_t;

    state_t             state_reg;
    mode_t              mode_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [PAY_W-1:0]   pay_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   iss_reg;
    logic               pend_reg;
    logic [CNT_W-1:0]   pend_idx_reg;
    logic [CNT_W-1:0]   slot_reg;
    status_t            status_reg;
    logic [PAY_W-1:0]   fpay_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic [PAY_W-1:0]    out_fpay_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic [KEY_W-1:0]   key_rdata;
    logic [PAY_W-1:0]   pay_rdata;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [KEY_W-1:0]   mem_wkey;
    logic [PAY_W-1:0]   mem_wpay;

    logic               hit;
    logic               scan_miss;
    logic               iss_live;
    logic               full;
    logic [CNT_W-1:0]   last_idx;
    logic [CNT_W-1:0]   shift_dst;

    assign hit       = pend_reg && (key_rdata == key_reg);
    assign iss_live  = iss_reg < count_reg;
    assign scan_miss = !pend_reg && !iss_live;
    assign full      = count_reg >= CNT_W'(DEPTH);
    assign last_idx  = count_reg - CNT_W'(1);
    assign shift_dst = pend_idx_reg - CNT_W'(1);

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.position      = out_pos_reg;
    assign rsp.found_payload = out_fpay_reg;
    assign rsp.entry_count   = out_count_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wkey  = key_reg;
        mem_wpay  = pay_reg;
        case (state_reg)
            S_SCAN:
            begin
                mem_we = scan_miss && (mode_reg == MODE_INSERT) && !full;
            end
            S_SWAP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg[IDX_W-1:0];
                mem_wkey  = key_rdata;
                mem_wpay  = pay_rdata;
            end
            S_SHIFT:
            begin
                mem_we    = pend_reg;
                mem_waddr = shift_dst[IDX_W-1:0];
                mem_wkey  = key_rdata;
                mem_wpay  = pay_rdata;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    ukt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wkey),
        .raddr (iss_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    ukt_ram #(
        .WIDTH (PAY_W),
        .DEPTH (DEPTH)
    ) u_pay_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wpay),
        .raddr (iss_reg[IDX_W-1:0]),
        .rdata (pay_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg   <= mode_t'(req.mode);
                        key_reg    <= req.key;
                        pay_reg    <= req.payload;
                        iss_reg    <= '0;
                        pend_reg   <= 1'b0;
                        slot_reg   <= '0;
                        fpay_reg   <= '0;
                        status_reg <= ST_OK;
                        if (req.key == '0)
                        begin
                            status_reg <= ST_INVALID;
                            state_reg  <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    pend_reg     <= iss_live;
                    pend_idx_reg <= iss_reg;
                    if (iss_live)
                    begin
                        iss_reg <= iss_reg + CNT_W'(1);
                    end
                    if (hit)
                    begin
                        pend_reg <= 1'b0;
                        case (mode_reg)
                            MODE_INSERT:
                            begin
                                status_reg <= ST_DUP;
                                state_reg  <= S_FIN;
                            end
                            MODE_LOOKUP:
                            begin
                                slot_reg  <= pend_idx_reg;
                                fpay_reg  <= pay_rdata;
                                state_reg <= S_FIN;
                            end
                            MODE_SWAP:
                            begin
                                slot_reg <= pend_idx_reg;
                                fpay_reg <= pay_rdata;
                                if (pend_idx_reg == last_idx)
                                begin
                                    count_reg <= last_idx;
                                    state_reg <= S_FIN;
                                end
                                else
                                begin
                                    iss_reg   <= last_idx;
                                    state_reg <= S_SWAP_RD;
                                end
                            end
                            default:
                            begin
                                slot_reg  <= pend_idx_reg;
                                fpay_reg  <= pay_rdata;
                                iss_reg   <= pend_idx_reg + CNT_W'(1);
                                state_reg <= S_SHIFT;
                            end
                        endcase
                    end
                    else if (scan_miss)
                    begin
                        state_reg <= S_FIN;
                        if (mode_reg != MODE_INSERT)
                        begin
                            status_reg <= ST_NOTFOUND;
                        end
                        else if (full)
                        begin
                            status_reg <= ST_FULL;
                        end
                        else
                        begin
                            slot_reg  <= count_reg;
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                end
                S_SWAP_RD:
                begin
                    state_reg <= S_SWAP_WR;
                end
                S_SWAP_WR:
                begin
                    count_reg <= last_idx;
                    state_reg <= S_FIN;
                end
                S_SHIFT:
                begin
                    pend_reg     <= iss_live;
                    pend_idx_reg <= iss_reg;
                    if (iss_live)
                    begin
                        iss_reg <= iss_reg + CNT_W'(1);
                    end
                    if (!pend_reg && !iss_live)
                    begin
                        count_reg <= last_idx;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_pos_reg    <= POS_W'(slot_reg);
                        out_fpay_reg   <= fpay_reg;
                        out_count_reg  <= COUNT_W'(count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/ukt_checker.sv */
module ukt_checker
    import ukt_pkg::*;
#(
    parameter int DEPTH = UKT_DEPTH
) (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [POS_W-1:0]    rsp_position,
    input logic [PAY_W-1:0]    rsp_found_payload,
    input logic [COUNT_W-1:0]  rsp_entry_count
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_position)
            && $stable(rsp_found_payload) && $stable(rsp_entry_count))
        else $error("response changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_position == '0)
            && (rsp_found_payload == '0))
        else $error("error response carries position or payload");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (DEPTH < (1 << COUNT_W)) |-> (32'(rsp_entry_count) <= 32'(DEPTH)))
        else $error("entry count above table depth");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_OK) && (DEPTH <= (1 << POS_W))
            |-> (COUNT_W'(rsp_position) <= rsp_entry_count))
        else $error("position beyond occupied slots");

endmodule

bind unordered_key_table ukt_checker #(
    .DEPTH (DEPTH)
) u_ukt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_position      (rsp.position),
    .rsp_found_payload (rsp.found_payload),
    .rsp_entry_count   (rsp.entry_count)
);

/* tb/unordered_key_table_tb.sv */
`timescale 1ns / 1ps

module unordered_key_table_tb;
    import ukt_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int TAIL_CYCLES  = 80;
    localparam int HOLD_AFTER   = 450;
    localparam int HOLD_CYCLES  = 400;

    localparam int PHASE_FILL  = 0;
    localparam int PHASE_DRAIN = 1;
    localparam int PHASE_MIXED = 2;

    localparam int RX_OPEN  = 0;
    localparam int RX_COIN  = 1;
    localparam int RX_TIGHT = 2;

    typedef struct {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [PAY_W-1:0]   found_payload;
        logic [COUNT_W-1:0] entry_count;
    } answer_t;

    typedef struct {
        mode_t            mode;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        bit               pinned;
        answer_t          answer;
    } request_t;

    logic clk;
    logic rst_n;

    ukt_req_if req_bus();
    ukt_rsp_if rsp_bus();

    unordered_key_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    logic [KEY_W-1:0] shadow_keys     [UKT_DEPTH];
    logic [PAY_W-1:0] shadow_payloads [UKT_DEPTH];
    int               shadow_count;

    answer_t  pending_answers  [$];
    request_t offered_requests [$];

    int       failures      = 0;
    int       answers_taken = 0;
    int       burst_left    = 0;
    answer_t  wanted;
    answer_t  predicted;
    request_t taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #6ms;
        $display("unordered_key_table_tb: FAIL");
        $finish;
    end

    function automatic answer_t table_update(mode_t m, logic [KEY_W-1:0] k,
                                             logic [PAY_W-1:0] p);
        answer_t r;
        int      slot;
        int      last;
        r.status        = ST_OK;
        r.position      = '0;
        r.found_payload = '0;
        if (k == '0)
        begin
            r.status = ST_INVALID;
        end
        else
        begin
            slot = UKT_DEPTH;
            for (int i = 0; i < shadow_count; i++)
            begin
                if (slot == UKT_DEPTH && shadow_keys[i] == k)
                    slot = i;
            end
            if (m == MODE_INSERT)
            begin
                if (slot < UKT_DEPTH)
                    r.status = ST_DUP;
                else if (shadow_count >= UKT_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    r.position                    = POS_W'(shadow_count);
                    shadow_keys[shadow_count]     = k;
                    shadow_payloads[shadow_count] = p;
                    shadow_count++;
                end
            end
            else if (slot >= UKT_DEPTH)
            begin
                r.status = ST_NOTFOUND;
            end
            else
            begin
                r.position      = POS_W'(slot);
                r.found_payload = shadow_payloads[slot];
                if (m != MODE_LOOKUP)
                begin
                    last = shadow_count - 1;
                    if (m == MODE_SWAP)
                    begin
                        shadow_keys[slot]     = shadow_keys[last];
                        shadow_payloads[slot] = shadow_payloads[last];
                    end
                    else
                    begin
                        for (int i = slot; i < last; i++)
                        begin
                            shadow_keys[i]     = shadow_keys[i + 1];
                            shadow_payloads[i] = shadow_payloads[i + 1];
                        end
                    end
                    shadow_keys[last]     = '0;
                    shadow_payloads[last] = '0;
                    shadow_count          = last;
                end
            end
        end
        r.entry_count = COUNT_W'(shadow_count);
        return r;
    endfunction

    function automatic request_t make_row(mode_t m, logic [KEY_W-1:0] k,
                                          logic [PAY_W-1:0] p, bit pin,
                                          status_t st, int pos,
                                          logic [PAY_W-1:0] fpay, int cnt);
        request_t row;
        row.mode                 = m;
        row.key                  = k;
        row.payload              = p;
        row.pinned               = pin;
        row.answer.status        = st;
        row.answer.position      = POS_W'(pos);
        row.answer.found_payload = fpay;
        row.answer.entry_count   = COUNT_W'(cnt);
        return row;
    endfunction

    function automatic mode_t choose_mode(int phase);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            PHASE_FILL:
                return roll < 65 ? MODE_INSERT : roll < 80 ? MODE_LOOKUP :
                       roll < 90 ? MODE_SWAP : MODE_SHIFT;
            PHASE_DRAIN:
                return roll < 15 ? MODE_INSERT : roll < 35 ? MODE_LOOKUP :
                       roll < 67 ? MODE_SWAP : MODE_SHIFT;
            default:
                return roll < 25 ? MODE_INSERT : roll < 50 ? MODE_LOOKUP :
                       roll < 75 ? MODE_SWAP : MODE_SHIFT;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] choose_key(mode_t m);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return '0;
        if (roll < 8)
            return KEY_W'($urandom);
        if (roll < 60 && m != MODE_INSERT && shadow_count > 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        return KEY_W'($urandom_range(1, 48));
    endfunction

    task automatic report_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field, want_v, got_v);
            failures++;
        end
    endtask

    task automatic send_request(request_t row);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        offered_requests.push_back(row);
        req_bus.valid   <= 1'b1;
        req_bus.mode    <= row.mode;
        req_bus.key     <= row.key;
        req_bus.payload <= row.payload;
        do
            @(posedge clk);
        while (!req_bus.ready);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                answers_taken++;
                if (pending_answers.size() == 0)
                begin
                    $display("%0t unexpected transfer: status %0d position %0d count %0d",
                             $time, rsp_bus.status, rsp_bus.position, rsp_bus.entry_count);
                    failures++;
                end
                else
                begin
                    wanted = pending_answers.pop_front();
                    report_field("status", 32'(wanted.status), 32'(rsp_bus.status));
                    report_field("position", 32'(wanted.position), 32'(rsp_bus.position));
                    report_field("found_payload", wanted.found_payload,
                                 rsp_bus.found_payload);
                    report_field("entry_count", 32'(wanted.entry_count),
                                 32'(rsp_bus.entry_count));
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                taken     = offered_requests.pop_front();
                predicted = table_update(mode_t'(req_bus.mode), req_bus.key,
                                         req_bus.payload);
                pending_answers.push_back(taken.pinned ? taken.answer : predicted);
            end
        end
    end

    initial
    begin
        int rx_style;
        int rx_left;
        bit held;
        rx_style = RX_OPEN;
        rx_left  = 0;
        held     = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && answers_taken >= HOLD_AFTER)
            begin
                held = 1'b1;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_style = $urandom_range(RX_OPEN, RX_TIGHT);
                    rx_left  = $urandom_range(10, 80);
                end
                rx_left--;
                case (rx_style)
                    RX_OPEN:  rsp_bus.ready <= 1'b1;
                    RX_COIN:  rsp_bus.ready <= 1'($urandom_range(0, 1));
                    default:  rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        request_t directed_rows [$];
        request_t row;
        int       sent;
        int       phase;
        int       phase_len;
        rst_n           = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.mode    = MODE_INSERT;
        req_bus.key     = '0;
        req_bus.payload = '0;
        rsp_bus.ready   = 1'b0;
        shadow_count    = 0;
        for (int i = 0; i < UKT_DEPTH; i++)
        begin
            shadow_keys[i]     = '0;
            shadow_payloads[i] = '0;
        end

        directed_rows = '{
            make_row(MODE_LOOKUP, 31'd5, 32'h0, 1, ST_NOTFOUND, 0, 32'h0, 0),
            make_row(MODE_INSERT, 31'd0, 32'hFFFF_FFFF, 1, ST_INVALID, 0, 32'h0, 0),
            make_row(MODE_LOOKUP, 31'd0, 32'h0, 1, ST_INVALID, 0, 32'h0, 0),
            make_row(MODE_SWAP, 31'd0, 32'h0, 1, ST_INVALID, 0, 32'h0, 0),
            make_row(MODE_SHIFT, 31'd0, 32'h0, 1, ST_INVALID, 0, 32'h0, 0),
            make_row(MODE_SWAP, 31'd7, 32'h0, 1, ST_NOTFOUND, 0, 32'h0, 0),
            make_row(MODE_SHIFT, 31'd7, 32'h0, 1, ST_NOTFOUND, 0, 32'h0, 0),
            make_row(MODE_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK, 0, 32'h0, 1),
            make_row(MODE_INSERT, 31'd1, 32'h0, 1, ST_OK, 1, 32'h0, 2),
            make_row(MODE_INSERT, 31'h7FFF_FFFF, 32'h0, 1, ST_DUP, 0, 32'h0, 2),
            make_row(MODE_LOOKUP, 31'h7FFF_FFFF, 32'h0, 1, ST_OK, 0, 32'hFFFF_FFFF, 2),
            make_row(MODE_LOOKUP, 31'd1, 32'h0, 0, ST_OK, 0, 32'h0, 0),
            make_row(MODE_INSERT, 31'd2, 32'h0000_0001, 0, ST_OK, 0, 32'h0, 0),
            make_row(MODE_INSERT, 31'd3, 32'h8000_0000, 0, ST_OK, 0, 32'h0, 0),
            make_row(MODE_INSERT, 31'd4, 32'h5A5A_A5A5, 0, ST_OK, 0, 32'h0, 0),
            make_row(MODE_SHIFT, 31'h7FFF_FFFF, 32'h0, 1, ST_OK, 0, 32'hFFFF_FFFF, 4),
            make_row(MODE_LOOKUP, 31'd4, 32'h0, 0, ST_OK, 0, 32'h0, 0),
            make_row(MODE_SWAP, 31'd1, 32'h0, 0, ST_OK, 0, 32'h0, 0),
            make_row(MODE_SWAP, 31'd3, 32'h0, 0, ST_OK, 0, 32'h0, 0),
            make_row(MODE_SHIFT, 31'd2, 32'h0, 0, ST_OK, 0, 32'h0, 0),
            make_row(MODE_LOOKUP, 31'd3, 32'h0, 1, ST_NOTFOUND, 0, 32'h0, 1),
            make_row(MODE_SHIFT, 31'd99, 32'h0, 1, ST_NOTFOUND, 0, 32'h0, 1),
            make_row(MODE_SHIFT, 31'd4, 32'h0, 0, ST_OK, 0, 32'h0, 0),
            make_row(MODE_INSERT, 31'h4000_0000, 32'h1234_5678, 0, ST_OK, 0, 32'h0, 0)
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase     = $urandom_range(PHASE_FILL, PHASE_MIXED);
            phase_len = $urandom_range(30, 120);
            for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++)
            begin
                row.mode    = choose_mode(phase);
                row.key     = choose_key(row.mode);
                row.payload = $urandom;
                row.pinned  = 1'b0;
                row.answer  = '{ST_OK, '0, '0, '0};
                send_request(row);
                sent++;
            end
        end

        req_bus.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("unordered_key_table_tb: PASS");
        else
            $display("unordered_key_table_tb: FAIL");
        $finish;
    end

endmodule
